### rtl/core/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared constants, types and the tanh table for the ladder low-pass filter.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int TANH_TABLE_DEPTH = 256;
  localparam int STAGE_COUNT      = 4;
  localparam int STAGE_W          = $clog2(STAGE_COUNT);
  localparam int TANH_IDX_W       = $clog2(TANH_TABLE_DEPTH);
  // m * depth with m below 2^31
  localparam int TANH_SCL_W       = 31 + $clog2(TANH_TABLE_DEPTH + 1);

  localparam logic [29:0] PI_Q28  = 30'd843314857;
  localparam int          MUL_W   = 34;
  localparam int          PROD_W  = 2 * MUL_W;

  // Taylor series argument for exp(-16/DEPTH), Q.32
  localparam logic [63:0] TANH_R  = (64'd16 << 32) / 64'(TANH_TABLE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_OUTPUT_GAIN     = 2'd0;
  localparam logic [1:0] CFG_DRIVE_VOLTAGE   = 2'd1;
  localparam logic [1:0] CFG_THERMAL_VOLTAGE = 2'd2;

  typedef logic [TANH_TABLE_DEPTH:0][31:0] tanh_tab_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // long division, only evaluated while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] base;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    tanh_tab_t   tab;
    r    = TANH_R;
    term = 64'd1 << 32;
    pos  = term;
    neg  = 64'd0;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * r) >> 32, 64'(n));
      if (n[0]) neg = neg + term;
      else      pos = pos + term;
    end
    base = pos - neg;
    p    = 64'd1 << 32;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      den    = (64'd1 << 32) + p;
      num    = ((64'd1 << 32) - p) << 28;
      tab[i] = 32'(udiv64(num + (den >> 1), den));
      p      = (p * base + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647)       return 32'sh7fffffff;
    else if (v < -72'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

### rtl/core/lpf_mul.sv
// ----------------------------------------------------------------------------
// lpf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lpf_mul (
  input  logic                             clk_i,
  input  logic signed [lpf_pkg::MUL_W-1:0]  op_a_i,
  input  logic signed [lpf_pkg::MUL_W-1:0]  op_b_i,
  output logic signed [lpf_pkg::PROD_W-1:0] prod_o
);
  import lpf_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

### rtl/core/lpf_div.sv
// ----------------------------------------------------------------------------
// lpf_div
// Restoring unsigned divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  output lpf_pkg::div_stat_t  stat_o,
  output logic [63:0]         quotient_o
);
  import lpf_pkg::*;

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

### rtl/core/lpf_tanh_lut.sv
// ----------------------------------------------------------------------------
// lpf_tanh_lut
// Tanh table lookup: base entry, slope and interpolation fraction.
// ----------------------------------------------------------------------------
module lpf_tanh_lut (
  input  logic [30:0] mag_i,
  output logic [31:0] lo_o,
  output logic [31:0] slope_o,
  output logic [30:0] frac_o
);
  import lpf_pkg::*;

  logic [TANH_SCL_W-1:0] scaled;
  logic [TANH_IDX_W-1:0] idx;
  logic [31:0]           hi;

  assign scaled = TANH_SCL_W'(mag_i) * TANH_SCL_W'(TANH_TABLE_DEPTH);
  assign idx    = scaled[31 +: TANH_IDX_W];
  assign frac_o = scaled[30:0];
  assign lo_o   = TANH_TAB[idx];
  assign hi     = TANH_TAB[(TANH_IDX_W+1)'(idx) + (TANH_IDX_W+1)'(1)];
  // table is monotonic, but clamp the slope the same way anyway
  assign slope_o = (hi >= lo_o) ? (hi - lo_o) : 32'd0;

endmodule

### rtl/core/ladder_lowpass_filter.sv
// ----------------------------------------------------------------------------
// ladder_lowpass_filter
// Four-stage nonlinear ladder low-pass filter, one sample per request.
// ----------------------------------------------------------------------------
// The time from request to result is set by six passes through the shared
// divider plus the multiplier steps around them.
// A new sample is taken only after the last one is done; in_stall_o is high while busy.
// The result register lets the next request in while a result still waits.
// Reset: asynchronous, active low; clears the stage state, the sequencer and
// restores the configuration registers to their defaults.
module ladder_lowpass_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] sample_in_i,
  input  logic [23:0]        cutoff_i,
  input  logic [22:0]        resonance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sample_out_o
);
  import lpf_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PIF_M = 5'd1;
  localparam logic [4:0] ST_PIF   = 5'd2;
  localparam logic [4:0] ST_T_M   = 5'd3;
  localparam logic [4:0] ST_T_D   = 5'd4;
  localparam logic [4:0] ST_T_W   = 5'd5;
  localparam logic [4:0] ST_A_M   = 5'd6;
  localparam logic [4:0] ST_A     = 5'd7;
  localparam logic [4:0] ST_DRV_M = 5'd8;
  localparam logic [4:0] ST_FB_M  = 5'd9;
  localparam logic [4:0] ST_FB    = 5'd10;
  localparam logic [4:0] ST_VD    = 5'd11;
  localparam logic [4:0] ST_VW    = 5'd12;
  localparam logic [4:0] ST_TH_L  = 5'd13;
  localparam logic [4:0] ST_TH_M  = 5'd14;
  localparam logic [4:0] ST_TH    = 5'd15;
  localparam logic [4:0] ST_SD_M  = 5'd16;
  localparam logic [4:0] ST_SD    = 5'd17;
  localparam logic [4:0] ST_SI    = 5'd18;
  localparam logic [4:0] ST_O1_M  = 5'd19;
  localparam logic [4:0] ST_O2_M  = 5'd20;
  localparam logic [4:0] ST_O     = 5'd21;

  logic [4:0] state_q, state_d;

  // configuration
  logic signed [31:0] gain_q;
  logic [23:0]        drive_q;
  logic [23:0]        vt_q;
  logic [23:0]        vt_eff;

  // filter state
  logic signed [31:0] stage_out_q [STAGE_COUNT];
  logic signed [31:0] stage_delta_q [STAGE_COUNT];
  logic signed [31:0] stage_integ_q [STAGE_COUNT];

  // per-sample working registers
  logic signed [23:0] x_q;
  logic [23:0]        f_q;
  logic [22:0]        k_q;
  logic [30:0]        pif_q;
  logic signed [31:0] t_q;
  logic signed [31:0] a_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] v_q;
  logic signed [31:0] dv_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] u_q;
  logic               qneg_q;
  logic               fb_q;
  logic [STAGE_W-1:0] s_q;
  logic [31:0]        lo_q;
  logic [31:0]        slope_q;
  logic [30:0]        frac_q;
  logic               big_q;
  logic               out_valid_q;
  logic signed [31:0] out_data_q;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic [63:0]              div_num;
  logic [31:0]              div_den;
  div_stat_t                div_stat;
  logic [63:0]              div_q;

  logic [63:0]        u_mag;
  logic [31:0]        gain_mag;
  logic [31:0]        lut_lo, lut_slope;
  logic [30:0]        lut_frac;
  logic [31:0]        tanh_mag;
  logic signed [31:0] tanh_val;
  logic signed [31:0] vp;
  logic signed [32:0] dsum;
  logic [63:0]        prod_mag;
  logic               out_neg;
  logic signed [31:0] out_res;
  logic               out_free;
  logic               in_acc;

  assign vt_eff   = (vt_q == 24'd0) ? 24'd1 : vt_q;
  assign u_mag    = u_q[63] ? 64'(-u_q) : 64'(u_q);
  assign gain_mag = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  lpf_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  lpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  lpf_tanh_lut u_lut (
    .mag_i   (u_mag[30:0]),
    .lo_o    (lut_lo),
    .slope_o (lut_slope),
    .frac_o  (lut_frac)
  );

  assign tanh_mag = big_q ? TANH_TAB[TANH_TABLE_DEPTH]
                          : lo_q + 32'((prod + 68'sd1073741824) >>> 31);
  assign tanh_val = u_q[63] ? -$signed(tanh_mag) : $signed(tanh_mag);

  assign dsum = 33'(dv_q) + 33'(stage_delta_q[s_q]);
  assign vp   = sat32(72'(stage_integ_q[s_q]) + 72'(dsum >>> 1));

  assign prod_mag = 64'(acc_q) + 64'((prod + 68'sd134217728) >>> 28);
  assign out_neg  = u_q[63] != gain_q[31];
  always_comb begin
    if (out_neg) begin
      out_res = (prod_mag > 64'h8000_0000) ? 32'sh80000000 : 32'(-prod_mag);
    end else begin
      out_res = (prod_mag > 64'h7fff_ffff) ? 32'sh7fffffff : $signed(prod_mag[31:0]);
    end
  end

  // operand selection and next state
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PIF_M;
      end
      ST_PIF_M: begin
        mul_a   = MUL_W'(f_q);
        mul_b   = MUL_W'(PI_Q28);
        state_d = ST_PIF;
      end
      ST_PIF: state_d = ST_T_M;
      ST_T_M: begin
        mul_a   = MUL_W'(pif_q);
        mul_b   = 34'sd268435456 - $signed(MUL_W'(pif_q));
        state_d = ST_T_D;
      end
      ST_T_D: begin
        div_start = 1'b1;
        div_num   = prod[PROD_W-1] ? 64'(-prod) : 64'(prod);
        div_den   = 32'd268435456 + 32'(pif_q);
        state_d   = ST_T_W;
      end
      ST_T_W: begin
        if (div_stat.done) state_d = ST_A_M;
      end
      ST_A_M: begin
        mul_a   = MUL_W'(t_q);
        mul_b   = MUL_W'(vt_eff);
        state_d = ST_A;
      end
      ST_A: state_d = ST_DRV_M;
      ST_DRV_M: begin
        mul_a   = MUL_W'(drive_q);
        mul_b   = MUL_W'(x_q);
        state_d = ST_FB_M;
      end
      ST_FB_M: begin
        mul_a   = MUL_W'(k_q);
        mul_b   = MUL_W'(stage_integ_q[STAGE_COUNT-1]);
        state_d = ST_FB;
      end
      ST_FB: state_d = ST_VD;
      ST_VD: begin
        div_start = 1'b1;
        div_num   = (v_q[31] ? 64'(-64'(v_q)) : 64'(v_q)) << 23;
        div_den   = 32'(vt_eff);
        state_d   = ST_VW;
      end
      ST_VW: begin
        if (div_stat.done) state_d = ST_TH_L;
      end
      ST_TH_L: state_d = ST_TH_M;
      ST_TH_M: begin
        mul_a   = MUL_W'(slope_q);
        mul_b   = MUL_W'(frac_q);
        state_d = ST_TH;
      end
      ST_TH: begin
        if (fb_q) state_d = ST_SD_M;
        else if (s_q == STAGE_W'(STAGE_COUNT - 1)) state_d = ST_O1_M;
        else state_d = ST_SD_M;
      end
      ST_SD_M: begin
        mul_a   = MUL_W'(a_q);
        mul_b   = MUL_W'(prev_q) - MUL_W'(stage_out_q[s_q]);
        state_d = ST_SD;
      end
      ST_SD: state_d = ST_SI;
      ST_SI: state_d = ST_VD;
      ST_O1_M: begin
        mul_a   = MUL_W'(u_mag[60:28]);
        mul_b   = MUL_W'(gain_mag);
        state_d = ST_O2_M;
      end
      ST_O2_M: begin
        mul_a   = MUL_W'(u_mag[27:0]);
        mul_b   = MUL_W'(gain_mag);
        state_d = ST_O;
      end
      ST_O: begin
        // keep the low product alive while the result register is occupied
        mul_a   = MUL_W'(u_mag[27:0]);
        mul_b   = MUL_W'(gain_mag);
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= 32'sd16777216;
      drive_q     <= 24'd867382;
      vt_q        <= 24'd433691;
      out_valid_q <= 1'b0;
      fb_q        <= 1'b0;
      s_q         <= '0;
      for (int i = 0; i < STAGE_COUNT; i++) begin
        stage_out_q[i]   <= '0;
        stage_delta_q[i] <= '0;
        stage_integ_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_OUTPUT_GAIN:     gain_q  <= $signed(cfg_data_i);
          CFG_DRIVE_VOLTAGE:   drive_q <= cfg_data_i[23:0];
          CFG_THERMAL_VOLTAGE: vt_q    <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (state_q == ST_O && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_FB: fb_q <= 1'b1;
        ST_SI: begin
          fb_q                  <= 1'b0;
          stage_delta_q[s_q]    <= dv_q;
          stage_integ_q[s_q]    <= vp;
        end
        ST_TH: begin
          if (fb_q) begin
            s_q <= '0;
          end else begin
            stage_out_q[s_q] <= tanh_val;
            if (s_q != STAGE_W'(STAGE_COUNT - 1)) s_q <= s_q + STAGE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
      f_q <= cutoff_i;
      k_q <= resonance_i;
    end
    case (state_q)
      ST_PIF: pif_q <= 31'((prod + 68'sd8388608) >>> 24);
      ST_T_D: qneg_q <= prod[PROD_W-1];
      ST_T_W: t_q <= qneg_q ? 32'(-div_q) : 32'(div_q);
      ST_A:   a_q <= sat32(72'((prod + 68'sd2097152) >>> 22));
      ST_FB_M: acc_q <= 64'((prod + 68'sd262144) >>> 19);
      ST_FB:  v_q <= sat32(72'(acc_q) + 72'((prod + 68'sd524288) >>> 20));
      ST_VD:  qneg_q <= v_q[31];
      ST_VW:  u_q <= qneg_q ? -$signed(div_q) : $signed(div_q);
      ST_TH_L: begin
        lo_q    <= lut_lo;
        slope_q <= lut_slope;
        frac_q  <= lut_frac;
        big_q   <= u_mag[63:31] != 33'd0;
      end
      ST_TH:  prev_q <= fb_q ? -tanh_val : tanh_val;
      ST_SD:  dv_q <= sat32(72'((prod + 68'sd134217728) >>> 28));
      ST_SI:  v_q <= vp;
      ST_O2_M: acc_q <= 64'(prod);
      ST_O: begin
        if (out_free) out_data_q <= out_res;
      end
      default: ;
    endcase
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

### rtl/core/lpf_checker.sv
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks of the ladder filter's request and result handshakes.
// ----------------------------------------------------------------------------
module lpf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [1:0]         cfg_index_i,
  input logic [31:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [23:0] sample_in_i,
  input logic [23:0]        cutoff_i,
  input logic [22:0]        resonance_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] sample_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o))
    else $error("stalled result changed");

  // a request keeps the block busy for the following cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready right after a request");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in progress");

endmodule

bind ladder_lowpass_filter lpf_checker u_lpf_checker (.*);
